/* rtl/core/rnde_pkg.sv */
`timescale 1ns / 1ps

package rnde_pkg;

   // Line store and frame limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Field widths
   localparam int DIM_W = 12;
   localparam int THR_W = 10;
   localparam int CHN_W = 8;
   localparam int SUM_W = 10;

   localparam int DIM_MAX    = (1 << DIM_W) - 1;
   localparam int WIDTH_LIM  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int HEIGHT_LIM = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = DIM_W + 1;
   localparam int POS_W   = ROW_W + DIM_W;
   localparam int TOTAL_W = $clog2(WIDTH_LIM * HEIGHT_LIM + 1);
   localparam int LINE_W  = 2 * SUM_W;

   // Command queue between front and back
   localparam int CMD_DEPTH = 4;

   // Register map
   localparam int PADDR_W   = 4;
   localparam int REG_IDX_W = 2;
   localparam int PDATA_W   = 32;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [THR_W-1:0] THRESHOLD_RST    = 10'd100;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [CHN_W-1:0] red;
      logic [CHN_W-1:0] green;
      logic [CHN_W-1:0] blue;
   } rnde_req_type;

   typedef struct packed {
      logic edge_res;
      logic last;
   } rnde_rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [THR_W-1:0] threshold;
   } rnde_cfg_type;

   // One line store update, with what the back needs to score the centre pixel
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [SUM_W-1:0] bottom;
      logic             emit;
      logic             last;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
   } rnde_cmd_type;

endpackage

/* rtl/core/rnde_ram.sv */
`timescale 1ns / 1ps

module rnde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rnde_cmd_fifo.sv */
`timescale 1ns / 1ps

module rnde_cmd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rnde_pkg::rnde_cmd_type push_data,
   input  logic                  pop,
   output rnde_pkg::rnde_cmd_type head,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = $clog2(rnde_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(rnde_pkg::CMD_DEPTH + 1);

   rnde_pkg::rnde_cmd_type entry_ff [rnde_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(rnde_pkg::CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(rnde_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(rnde_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/rnde_front.sv */
`timescale 1ns / 1ps

module rnde_front (
   input  logic                   clock,
   input  logic                   reset,
   input  rnde_pkg::rnde_cfg_type cfg,
   input  logic                   geom_wr,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rnde_pkg::rnde_req_type req_data,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output rnde_pkg::rnde_cmd_type cmd_data
);

   localparam int DIM_W   = rnde_pkg::DIM_W;
   localparam int COL_W   = rnde_pkg::COL_W;
   localparam int ROW_W   = rnde_pkg::ROW_W;
   localparam int POS_W   = rnde_pkg::POS_W;
   localparam int OUT_W   = rnde_pkg::TOTAL_W;
   localparam int SUM_W   = rnde_pkg::SUM_W;
   localparam int EXT_W   = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
   localparam int CNT_W   = $clog2(OUT_W + 1);

   localparam logic [1:0] RB_IDLE  = 2'd0;
   localparam logic [1:0] RB_TOTAL = 2'd1;
   localparam logic [1:0] RB_POS   = 2'd2;
   localparam logic [1:0] RB_DIV   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [OUT_W-1:0] out_ff, out_in;
   logic [COL_W-1:0] ox_ff, ox_in;
   logic [OUT_W-1:0] oy_ff, oy_in;
   logic [OUT_W-1:0] total_ff, total_in;
   logic [DIM_W-1:0] div_rem_ff, div_rem_in;
   logic [OUT_W-1:0] div_quo_ff, div_quo_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [DIM_W-1:0]       w, h;
   logic [2*DIM_W-1:0]     area;
   logic [ROW_W+DIM_W-1:0] row_prod;
   logic [DIM_W:0]         div_shift;
   logic [DIM_W:0]         div_diff;
   logic                   div_ge;
   logic                   fire, pos_lt_total, out_done, is_drain_kind, drain;
   logic                   ignore, clear, update, emit, last;
   logic [SUM_W-1:0]       pix_sum, bottom;
   logic [EXT_W-1:0]       col_p1, ox_p1;
   logic                   col_wrap, ox_wrap;

   // Clamp the geometry to what the line store holds
   always_comb begin
      if (cfg.frame_width == '0) begin
         w = DIM_W'(1);
      end else if (cfg.frame_width > DIM_W'(rnde_pkg::WIDTH_LIM)) begin
         w = DIM_W'(rnde_pkg::WIDTH_LIM);
      end else begin
         w = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         h = DIM_W'(1);
      end else if (cfg.frame_height > DIM_W'(rnde_pkg::HEIGHT_LIM)) begin
         h = DIM_W'(rnde_pkg::HEIGHT_LIM);
      end else begin
         h = cfg.frame_height;
      end
   end

   assign area      = w * h;
   assign row_prod  = row_ff * w;
   assign div_shift = {div_rem_ff, div_quo_ff[OUT_W-1]};
   assign div_ge    = (div_shift >= {1'b0, w});
   assign div_diff  = div_shift - {1'b0, w};

   assign req_ready = (state_ff == RB_IDLE) && !cmd_full;
   assign fire      = req_valid && req_ready;

   // Classify the request
   assign pos_lt_total  = (pos_ff < POS_W'(total_ff));
   assign out_done      = (out_ff >= total_ff);
   assign is_drain_kind = (req_data.kind == rnde_pkg::KIND_DRAIN);
   assign drain         = is_drain_kind || !pos_lt_total;
   assign ignore        = is_drain_kind && pos_lt_total;
   assign clear         = !pos_lt_total && out_done;
   assign update        = !ignore && !clear;
   assign emit          = update && (pos_ff >= POS_W'(w) + 1'b1) && !out_done;
   assign last          = emit && ((OUT_W+1)'(out_ff) + 1'b1 == (OUT_W+1)'(total_ff));

   assign pix_sum = SUM_W'(req_data.red) + SUM_W'(req_data.green) + SUM_W'(req_data.blue);
   assign bottom  = drain ? '0 : pix_sum;

   assign col_p1   = EXT_W'(col_ff) + 1'b1;
   assign col_wrap = (col_p1 >= EXT_W'(w));
   assign ox_p1    = EXT_W'(ox_ff) + 1'b1;
   assign ox_wrap  = (ox_p1 >= EXT_W'(w));

   always_comb begin
      cmd_data.col      = col_ff;
      cmd_data.bottom   = bottom;
      cmd_data.emit     = emit;
      cmd_data.last     = last;
      cmd_data.top_ok   = (oy_ff != '0);
      cmd_data.bot_ok   = ((OUT_W+1)'(oy_ff) + 1'b1 < (OUT_W+1)'(h));
      cmd_data.left_ok  = (ox_ff != '0);
      cmd_data.right_ok = !ox_wrap;
   end

   assign cmd_push = fire && update;

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pos_in     = pos_ff;
      out_in     = out_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      total_in   = total_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         RB_TOTAL: begin
            total_in = OUT_W'(area);
            state_in = RB_POS;
         end
         RB_POS: begin
            pos_in     = POS_W'(row_prod) + POS_W'(col_ff);
            div_rem_in = '0;
            div_quo_in = out_ff;
            div_cnt_in = CNT_W'(OUT_W);
            state_in   = RB_DIV;
         end
         RB_DIV: begin
            // one quotient bit a cycle: out / w gives the output row and column
            div_rem_in = div_ge ? div_diff[DIM_W-1:0] : div_shift[DIM_W-1:0];
            div_quo_in = {div_quo_ff[OUT_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == CNT_W'(1)) begin
               ox_in    = COL_W'(div_rem_in);
               oy_in    = div_quo_in;
               state_in = RB_IDLE;
            end
         end
         RB_IDLE: begin
            if (fire) begin
               if (update) begin
                  if (col_wrap) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                     pos_in = pos_ff - POS_W'(col_ff) + POS_W'(w);
                  end else begin
                     col_in = COL_W'(col_p1);
                     pos_in = pos_ff + 1'b1;
                  end
                  if (emit) begin
                     out_in = out_ff + 1'b1;
                     if (ox_wrap) begin
                        ox_in = '0;
                        oy_in = oy_ff + 1'b1;
                     end else begin
                        ox_in = COL_W'(ox_p1);
                     end
                  end
               end
               if (clear || last) begin
                  col_in = '0;
                  row_in = '0;
                  pos_in = '0;
                  out_in = '0;
                  ox_in  = '0;
                  oy_in  = '0;
               end
            end
         end
         default: begin
            state_in = RB_IDLE;
         end
      endcase
      // a new geometry restarts the rebuild of the derived counters
      if (geom_wr) begin
         state_in = RB_TOTAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RB_TOTAL;
         col_ff   <= '0;
         row_ff   <= '0;
         pos_ff   <= '0;
         out_ff   <= '0;
         ox_ff    <= '0;
         oy_ff    <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pos_ff   <= pos_in;
         out_ff   <= out_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
   end

endmodule

/* rtl/core/rnde_back.sv */
`timescale 1ns / 1ps

module rnde_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rnde_pkg::THR_W-1:0]    threshold,
   input  logic                          cmd_valid,
   input  rnde_pkg::rnde_cmd_type        cmd_data,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rnde_pkg::rnde_rsp_type        rsp_data
);

   localparam int SUM_W     = rnde_pkg::SUM_W;
   localparam int LINE_W    = rnde_pkg::LINE_W;
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 3);

   logic                   s1_valid_ff, s1_valid_in;
   rnde_pkg::rnde_cmd_type s1_cmd_ff, s1_cmd_in;
   logic                   s1_fwd_ff, s1_fwd_in;
   logic [LINE_W-1:0]      s1_fwd_word_ff, s1_fwd_word_in;
   logic                   s2_valid_ff, s2_valid_in;
   rnde_pkg::rnde_cmd_type s2_cmd_ff;
   logic [SUM_W-1:0]       win_ff [9];
   logic [SUM_W-1:0]       win_in [9];

   rnde_pkg::rnde_rsp_type res_buf_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0]   res_wr_ff, res_wr_in;
   logic [RES_PTR_W-1:0]   res_rd_ff, res_rd_in;
   logic [RES_CNT_W-1:0]   res_cnt_ff, res_cnt_in;

   logic [LINE_W-1:0]    line_rd, line_word, line_wr;
   logic [SUM_W-1:0]     above, centre;
   logic [RES_CNT_W-1:0] pending;
   logic                 res_pop;
   logic [8:0]           nb_ok, nb_hit;
   logic [SUM_W-1:0]     diff;
   logic                 edge_hit;
   rnde_pkg::rnde_rsp_type res_word;

   // Pop only when every result in flight has a buffer slot waiting
   assign pending = res_cnt_ff + RES_CNT_W'(s1_valid_ff && s1_cmd_ff.emit)
                  + RES_CNT_W'(s2_valid_ff);
   assign cmd_pop = cmd_valid && (pending < RES_CNT_W'(RES_DEPTH));

   rnde_ram #(
      .WIDTH(LINE_W),
      .DEPTH(rnde_pkg::MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(s1_cmd_ff.col),
      .wr_data(line_wr),
      .rd_en  (cmd_pop),
      .rd_addr(cmd_data.col),
      .rd_data(line_rd)
   );

   // Take the word just written when the same column is read straight after
   assign line_word = s1_fwd_ff ? s1_fwd_word_ff : line_rd;
   assign above     = line_word[LINE_W-1:SUM_W];
   assign centre    = line_word[SUM_W-1:0];
   assign line_wr   = {centre, s1_cmd_ff.bottom};

   assign s1_valid_in    = cmd_pop;
   assign s1_cmd_in      = cmd_data;
   assign s1_fwd_in      = s1_valid_ff && (s1_cmd_ff.col == cmd_data.col);
   assign s1_fwd_word_in = line_wr;
   assign s2_valid_in    = s1_valid_ff && s1_cmd_ff.emit;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_valid_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = above;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = centre;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s1_cmd_ff.bottom;
      end
   end

   always_comb begin
      nb_ok[0] = s2_cmd_ff.top_ok && s2_cmd_ff.left_ok;
      nb_ok[1] = s2_cmd_ff.top_ok;
      nb_ok[2] = s2_cmd_ff.top_ok && s2_cmd_ff.right_ok;
      nb_ok[3] = s2_cmd_ff.left_ok;
      nb_ok[4] = 1'b0;
      nb_ok[5] = s2_cmd_ff.right_ok;
      nb_ok[6] = s2_cmd_ff.bot_ok && s2_cmd_ff.left_ok;
      nb_ok[7] = s2_cmd_ff.bot_ok;
      nb_ok[8] = s2_cmd_ff.bot_ok && s2_cmd_ff.right_ok;
   end

   // Eight absolute differences against the centre, side by side
   always_comb begin
      diff = '0;
      for (int i = 0; i < 9; i++) begin
         diff      = (win_ff[4] > win_ff[i]) ? win_ff[4] - win_ff[i] : win_ff[i] - win_ff[4];
         nb_hit[i] = (diff >= threshold);
      end
   end

   assign edge_hit          = |(nb_ok & nb_hit);
   assign res_word.edge_res = edge_hit;
   assign res_word.last     = s2_cmd_ff.last;

   assign rsp_valid = (res_cnt_ff != '0);
   assign rsp_data  = res_buf_ff[res_rd_ff];
   assign res_pop   = rsp_valid && rsp_ready;

   always_comb begin
      res_wr_in  = res_wr_ff;
      res_rd_in  = res_rd_ff;
      res_cnt_in = res_cnt_ff;
      if (s2_valid_ff) begin
         res_wr_in = res_wr_ff + 1'b1;
      end
      if (res_pop) begin
         res_rd_in = res_rd_ff + 1'b1;
      end
      if (s2_valid_ff && !res_pop) begin
         res_cnt_in = res_cnt_ff + 1'b1;
      end else if (res_pop && !s2_valid_ff) begin
         res_cnt_in = res_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         res_wr_ff   <= '0;
         res_rd_ff   <= '0;
         res_cnt_ff  <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         res_wr_ff   <= res_wr_in;
         res_rd_ff   <= res_rd_in;
         res_cnt_ff  <= res_cnt_in;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff      <= s1_cmd_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_word_ff <= s1_fwd_word_in;
      s2_cmd_ff      <= s1_cmd_ff;
      if (s2_valid_ff) begin
         res_buf_ff[res_wr_ff] <= res_word;
      end
   end

endmodule

/* rtl/core/rgb_neighbour_diff_edge_map.sv */
`timescale 1ns / 1ps
// Path: a request that completes a result reaches rsp via the queue, s1, s2 and the result
//    buffer; per stream, each pixel's flag comes one row plus one pixel of requests later.
// Throughput: one request per cycle while req_ready, set by the line store's read and write.
// Reset: counters and window clear; the line store is not cleared (entries read before
//    being written only ever face out-of-frame neighbours). req_ready stays low after
//    reset and each frame_width or frame_height write, during RB_TOTAL, RB_POS and RB_DIV.
module rgb_neighbour_diff_edge_map (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rnde_pkg::rnde_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rnde_pkg::rnde_rsp_type         rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rnde_pkg::PADDR_W-1:0]   paddr,
   input  logic [rnde_pkg::PDATA_W-1:0]   pwdata,
   output logic [rnde_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);

   localparam int DIM_W     = rnde_pkg::DIM_W;
   localparam int THR_W     = rnde_pkg::THR_W;
   localparam int PDATA_W   = rnde_pkg::PDATA_W;
   localparam int REG_IDX_W = rnde_pkg::REG_IDX_W;

   // Register file
   logic [DIM_W-1:0]     frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]     frame_height_ff, frame_height_in;
   logic [THR_W-1:0]     threshold_ff, threshold_in;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 geom_wr;
   rnde_pkg::rnde_cfg_type cfg;

   // Queue between the front and the back
   logic                   cmd_push, cmd_pop, cmd_full, cmd_empty;
   rnde_pkg::rnde_cmd_type cmd_in_data, cmd_head;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[rnde_pkg::PADDR_W-1:2];
   // width and height changes need the frame position rebuilt
   assign geom_wr = csr_wr && ((csr_idx == rnde_pkg::REG_FRAME_WIDTH)
                            || (csr_idx == rnde_pkg::REG_FRAME_HEIGHT));

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      threshold_in    = threshold_ff;
      if (csr_wr) begin
         case (csr_idx)
            rnde_pkg::REG_FRAME_WIDTH:  frame_width_in  = pwdata[DIM_W-1:0];
            rnde_pkg::REG_FRAME_HEIGHT: frame_height_in = pwdata[DIM_W-1:0];
            rnde_pkg::REG_THRESHOLD:    threshold_in    = pwdata[THR_W-1:0];
            default: begin
               // drop writes beyond the register map
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rnde_pkg::REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_ff);
         rnde_pkg::REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_ff);
         rnde_pkg::REG_THRESHOLD:    prdata = PDATA_W'(threshold_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rnde_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= rnde_pkg::FRAME_HEIGHT_RST;
         threshold_ff    <= rnde_pkg::THRESHOLD_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         threshold_ff    <= threshold_in;
      end
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;
   assign cfg.threshold    = threshold_ff;

   // Front: classify each request, advance the raster counters, queue line store work
   rnde_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .geom_wr  (geom_wr),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data)
   );

   // Queue: lets the front keep taking requests while results wait downstream
   rnde_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in_data),
      .pop      (cmd_pop),
      .head     (cmd_head),
      .full     (cmd_full),
      .empty    (cmd_empty)
   );

   // Back: line store, 3x3 window, eight compares and the result buffer
   rnde_back u_back (
      .clock    (clock),
      .reset    (reset),
      .threshold(cfg.threshold),
      .cmd_valid(!cmd_empty),
      .cmd_data (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Never queue work the queue cannot hold
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

   // Never take work from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from an empty queue");

   // Hold off requests while the frame position is rebuilt after a geometry write
   a_geom_stall: assert property (@(posedge clock) disable iff (reset)
      geom_wr |=> !req_ready)
      else $error("request taken during geometry rebuild");

endmodule

/* test/rnde_edge_checker.sv */
`timescale 1ns / 1ps

module rnde_edge_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  rnde_pkg::rnde_req_type       req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  rnde_pkg::rnde_rsp_type       rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rnde_pkg::PADDR_W-1:0] paddr,
   input  logic [rnde_pkg::PDATA_W-1:0] pwdata,
   input  logic                         pready,
   output int                           mismatch_count,
   output int                           flags_pending,
   output logic                         at_frame_start
);
   import rnde_pkg::*;

   // Expected flag, and whether every sum that decides edge_res has been written
   typedef struct packed {
      logic         edge_known;
      rnde_rsp_type flag;
   } flag_due_type;

   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [THR_W-1:0] thr_reg;

   logic [SUM_W-1:0] above_line  [MAX_WIDTH];
   logic [SUM_W-1:0] centre_line [MAX_WIDTH];
   bit               above_known  [MAX_WIDTH];
   bit               centre_known [MAX_WIDTH];
   logic [SUM_W-1:0] win [9];
   bit               win_known [9];
   int unsigned      col_in;
   int unsigned      row_in;
   longint unsigned  flags_out;

   flag_due_type edge_flags_due [$];

   assign at_frame_start = (col_in == 0) && (row_in == 0) && (flags_out == 0);

   // Advance the window by one request; returns 1 when a flag falls due.
   function automatic bit score_request(input rnde_req_type item, output flag_due_type due);
      int unsigned      w, h, col;
      longint unsigned  total, pos, ox, oy;
      bit               drain, hit, is_last, known;
      logic [SUM_W-1:0] bottom, a, b, d;
      int               r, c;
      due = '0;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      total = 64'(w) * 64'(h);
      pos = 64'(row_in) * 64'(w) + 64'(col_in);
      drain = (item.kind == KIND_DRAIN) || (pos >= total);
      if (drain && pos < total) return 1'b0;
      if (drain && flags_out >= total) begin
         col_in = 0;
         row_in = 0;
         flags_out = 0;
         return 1'b0;
      end
      bottom = drain ? '0 : (SUM_W'(item.red) + SUM_W'(item.green) + SUM_W'(item.blue));
      col = col_in % MAX_WIDTH;
      for (r = 0; r < 3; r++) begin
         win[r*3]         = win[r*3+1];
         win[r*3+1]       = win[r*3+2];
         win_known[r*3]   = win_known[r*3+1];
         win_known[r*3+1] = win_known[r*3+2];
      end
      win[2] = above_line[col];
      win[5] = centre_line[col];
      win[8] = bottom;
      win_known[2] = above_known[col];
      win_known[5] = centre_known[col];
      win_known[8] = 1'b1;
      above_line[col]   = centre_line[col];
      centre_line[col]  = bottom;
      above_known[col]  = centre_known[col];
      centre_known[col] = 1'b1;
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (pos < 64'(w) + 1 || flags_out >= total) return 1'b0;
      ox = flags_out % w;
      oy = flags_out / w;
      hit = 1'b0;
      known = win_known[4];
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            if (r == 0 && oy == 0) continue;
            if (r == 2 && oy + 1 >= h) continue;
            if (r == 1 && c == 1) continue;
            if (c == 0 && ox == 0) continue;
            if (c == 2 && ox + 1 >= w) continue;
            if (!win_known[r*3+c]) known = 1'b0;
            a = win[4];
            b = win[r*3+c];
            d = (a > b) ? a - b : b - a;
            if (d >= SUM_W'(thr_reg)) hit = 1'b1;
         end
      end
      is_last = (flags_out + 1 == total);
      due.edge_known = known;
      due.flag.edge_res = hit;
      due.flag.last = is_last;
      flags_out++;
      if (is_last) begin
         col_in = 0;
         row_in = 0;
         flags_out = 0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      flag_due_type entry, due;
      int           i;
      if (reset) begin
         width_reg = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         thr_reg = THRESHOLD_RST;
         for (i = 0; i < MAX_WIDTH; i++) begin
            above_line[i] = '0;
            centre_line[i] = '0;
            above_known[i] = 1'b0;
            centre_known[i] = 1'b0;
         end
         for (i = 0; i < 9; i++) begin
            win[i] = '0;
            win_known[i] = 1'b1;
         end
         col_in = 0;
         row_in = 0;
         flags_out = 0;
         edge_flags_due.delete();
         mismatch_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[REG_IDX_W+1:2])
               REG_FRAME_WIDTH:  width_reg = pwdata[DIM_W-1:0];
               REG_FRAME_HEIGHT: height_reg = pwdata[DIM_W-1:0];
               REG_THRESHOLD:    thr_reg = pwdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (score_request(req_data, entry)) edge_flags_due = {edge_flags_due, entry};
         end
         if (rsp_valid && rsp_ready) begin
            if (edge_flags_due.size() == 0) begin
               mismatch_count++;
               $error("unexpected result: edge_res %0b last %0b",
                      rsp_data.edge_res, rsp_data.last);
            end else begin
               due = edge_flags_due.pop_front();
               if (due.edge_known && (rsp_data.edge_res !== due.flag.edge_res)) begin
                  mismatch_count++;
                  $error("edge_res: expected %0b, actual %0b",
                         due.flag.edge_res, rsp_data.edge_res);
               end
               if (rsp_data.last !== due.flag.last) begin
                  mismatch_count++;
                  $error("last: expected %0b, actual %0b", due.flag.last, rsp_data.last);
               end
            end
         end
      end
      flags_pending = edge_flags_due.size();
   end

endmodule

/* test/rgb_neighbour_diff_edge_map_tb.sv */
`timescale 1ns / 1ps

module rgb_neighbour_diff_edge_map_tb;
   import rnde_pkg::*;

   // Stop point for the random part and a watchdog well above the slowest legal run
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 500000;
   // Settling time for requests still in the pipe after the last flag
   localparam int SETTLE_CYCLES = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   rnde_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rnde_rsp_type         rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [PADDR_W-1:0]   paddr = '0;
   logic [PDATA_W-1:0]   pwdata = '0;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;

   int   mismatch_count;
   int   flags_pending;
   logic at_frame_start;

   int   send_idle_pct = 15;
   int   recv_idle_pct = 56;
   int   cycle_count = 0;
   int   random_items = 0;
   int   cur_w = 640;
   int   cur_h = 480;
   bit   pause_due = 1'b1;

   rgb_neighbour_diff_edge_map dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   rnde_edge_checker edge_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .flags_pending  (flags_pending),
      .at_frame_start (at_frame_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Receiver: stall at random, at the rate of the current phase
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: a hung handshake or a lost flag ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request, idling beforehand at the sender's rate. Entered and left just
   // after a falling edge; valid is left high so back-to-back requests never drop it.
   task automatic send_req(input logic kind, input logic [23:0] rgb);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {kind, rgb};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every flag due has come, then let the pipe empty
   task automatic wait_flags_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (flags_pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup phase, then access phase; the write lands on the access edge
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram all three registers on an idle block; track the clamped geometry
   task automatic set_geometry(input int unsigned wv, input int unsigned hv,
                               input int unsigned thr);
      wait_flags_drained();
      write_reg(REG_FRAME_WIDTH, wv);
      write_reg(REG_FRAME_HEIGHT, hv);
      write_reg(REG_THRESHOLD, thr);
      cur_w = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
      cur_h = (hv == 0) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : hv);
   endtask

   // One frame in raster order followed by its flush. A cut at or beyond zero stops
   // the frame part-way, leaving the block mid-frame for the caller to disturb.
   task automatic send_frame(input int style, input int cut);
      int          n_pix, pause_at, i;
      logic [23:0] base, alt, px;
      n_pix = cur_w * cur_h;
      base = 24'($urandom);
      alt = 24'($urandom);
      pause_at = (pause_due || $urandom_range(0, 3) == 0) ?
                 int'($urandom_range(0, n_pix - 1)) : -1;
      for (i = 0; i < n_pix; i++) begin
         if (i == cut) return;
         // Stray drain inside the frame: the block must ignore it
         if ($urandom_range(0, 19) == 0) send_req(KIND_DRAIN, 24'($urandom));
         case (style)
            0: px = 24'($urandom);
            // Flat colour with faint texture, for small thresholds
            1: px = base ^ (24'($urandom) & 24'h030303);
            2: px = $urandom_range(0, 1) ? base : alt;
            default: px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         endcase
         send_req(KIND_PIXEL, px);
         random_items++;
         // Hold the sender until the block has caught up with every flag
         if (i == pause_at) begin
            wait_flags_drained();
            pause_due = 1'b0;
         end
      end
      // Flush: either kind acts as a drain once the frame is complete
      for (i = 0; i <= cur_w; i++) begin
         send_req(1'($urandom), 24'($urandom));
         random_items++;
      end
      // A drain at the start of the next frame is ignored
      if ($urandom_range(0, 3) == 0) send_req(KIND_DRAIN, 24'($urandom));
   endtask

   initial begin : stimulus
      int          style, i;
      int unsigned w_val, h_val, thr;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extreme channels, stray drain and threshold zero on a 3x2 frame
      set_geometry(3, 2, 0);
      send_req(KIND_PIXEL, 24'h000000);
      send_req(KIND_PIXEL, 24'hFFFFFF);
      send_req(KIND_DRAIN, 24'hFFFFFF);
      send_req(KIND_PIXEL, 24'hFF0000);
      send_req(KIND_PIXEL, 24'h00FF00);
      send_req(KIND_PIXEL, 24'h0000FF);
      send_req(KIND_PIXEL, 24'h804020);
      for (i = 0; i < 4; i++) send_req(KIND_DRAIN, 24'h000000);

      // Zero geometry clamps to 1x1, threshold above any sum; a pixel past the end drains
      set_geometry(0, 0, 1023);
      send_req(KIND_PIXEL, 24'hFFFFFF);
      send_req(KIND_PIXEL, 24'h000000);
      send_req(KIND_DRAIN, 24'h000000);

      // Black and white checkerboard at the largest meaningful threshold
      set_geometry(4, 3, 765);
      for (i = 0; i < 9; i++)
         send_req(KIND_PIXEL, ((i % 4 + i / 4) % 2) ? 24'hFFFFFF : 24'h000000);
      // Shrink the frame mid-way below what has been emitted: the next drain resets
      set_geometry(4, 1, 765);
      send_req(KIND_DRAIN, 24'h000000);

      // Random frames: sender light and receiver heavy, then swapped, then free running
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_items >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 15;
         end
         style = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0:       w_val = 0;
            1:       w_val = $urandom_range(13, 40);
            default: w_val = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       h_val = 0;
            1:       h_val = $urandom_range(9, 20);
            default: h_val = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 7))
            0:       thr = 0;
            1:       thr = 1023;
            2:       thr = 765;
            3:       thr = $urandom_range(766, 1023);
            4:       thr = $urandom_range(0, 12);
            default: thr = (style == 1) ? $urandom_range(0, 8) : $urandom_range(0, 765);
         endcase
         set_geometry(w_val, h_val, thr);
         if ($urandom_range(0, 9) == 0) begin
            // Broken frame: stop part-way, change geometry, then advance to a frame start
            send_frame(style, $urandom_range(0, cur_w * cur_h - 1));
            set_geometry($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 765));
            while (!at_frame_start) begin
               send_req(1'($urandom), 24'($urandom));
               random_items++;
            end
         end else begin
            send_frame(style, -1);
         end
      end

      // Register values beyond the line store clamp to it: start such a frame, then
      // move to a small geometry mid-way and flush to the next frame start
      set_geometry(4095, 4095, $urandom_range(0, 765));
      send_frame(0, 40);
      set_geometry(3, 2, $urandom_range(0, 765));
      while (!at_frame_start) begin
         send_req(1'($urandom), 24'($urandom));
      end

      wait_flags_drained();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
